// ----- rtl/c8core_pkg.sv -----
// ----------------------------------------------------------------------------
// c8core_pkg
// shared constants and types for the chip-8 instruction subset core
// ----------------------------------------------------------------------------
`default_nettype none
package c8core_pkg;
  localparam int DISPLAY_WIDTH  = 64;
  localparam int DISPLAY_HEIGHT = 32;
  localparam int MEMORY_BYTES   = 4096;

  localparam int MEM_AW = $clog2(MEMORY_BYTES);
  localparam int ROW_AW = $clog2(DISPLAY_HEIGHT);
  localparam int COL_AW = $clog2(DISPLAY_WIDTH);
  localparam int PIX_CNT = DISPLAY_WIDTH * DISPLAY_HEIGHT;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_EXEC = 2'd1;
  localparam logic [1:0] KIND_RPIX = 2'd2;
  localparam logic [1:0] KIND_RREG = 2'd3;

  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_LD   = 4'h6;
  localparam logic [3:0] OP_ADD  = 4'h7;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_DRW  = 4'hD;
  localparam logic [15:0] OPC_CLS = 16'h00E0;
  localparam logic [11:0] PC_START = 12'h200;

  typedef struct packed {
    logic          we;
    logic [ROW_AW-1:0] waddr;
    logic [DISPLAY_WIDTH-1:0] wdata;
    logic [ROW_AW-1:0] raddr;
  } disp_req_t;
endpackage
`default_nettype wire

// ----- rtl/c8core_pmem.sv -----
// ----------------------------------------------------------------------------
// c8core_pmem
// program memory, one write or read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module c8core_pmem import c8core_pkg::*; (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [MEM_AW-1:0] addr,
  input  wire logic [7:0]        wdata,
  output logic      [7:0]        rdata
);
  logic [7:0] mem [MEMORY_BYTES];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- rtl/c8core_disp.sv -----
// ----------------------------------------------------------------------------
// c8core_disp
// display row memory with per-row valid bits so reset reads as all off
// ----------------------------------------------------------------------------
`default_nettype none
module c8core_disp import c8core_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     clr,
  input  wire disp_req_t                req,
  output logic      [DISPLAY_WIDTH-1:0] rdata
);
  logic [DISPLAY_WIDTH-1:0] mem [DISPLAY_HEIGHT];
  logic [DISPLAY_HEIGHT-1:0] vld_r;
  logic [DISPLAY_WIDTH-1:0] raw_r;
  logic                     rv_r;
  always_ff @(posedge clk) begin
    if (req.we) mem[req.waddr] <= req.wdata;
    raw_r <= mem[req.raddr];
  end
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r <= '0;
      rv_r  <= 1'b0;
    end else begin
      rv_r <= vld_r[req.raddr];
      if (req.we) vld_r[req.waddr] <= 1'b1;
    end
  end
  assign rdata = rv_r ? raw_r : '0;
endmodule
`default_nettype wire

// ----- rtl/chip8_instruction_subset_core.sv -----
// ----------------------------------------------------------------------------
// chip8_instruction_subset_core
// chip-8 subset interpreter built around program and display memories
// ----------------------------------------------------------------------------
// usage: raise start with in_kind, in_address, in_data while busy is low; the
// item transfers at that edge and busy rises. exactly one result appears on
// the out_ ports for one cycle with out_valid high; the receiver cannot
// stall, so it must take it then.
// kinds: load byte, execute one instruction, read pixel, read v register.
// steps: load and register read go straight to the result; a pixel read first
// reads its display row; execute fetches the opcode with two reads through the
// single program memory port; clear screen needs no extra step (display rows
// carry valid bits cleared at once); a draw then walks its sprite rows, each
// a program memory read, a display row read and a write back.
// throughput: busy drops with the result cycle, so the next item can transfer
// at the edge that ends it.
// the display uses one read and one write port; draws are strictly
// read-modify-write per row so no forwarding is needed.
// reset: pc 0x200, index 0, registers and display cleared, collision 0.
// program memory holds undefined data until loaded.
// ----------------------------------------------------------------------------
`default_nettype none
module chip8_instruction_subset_core import c8core_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_kind,
  input  wire logic [11:0] in_address,
  input  wire logic [7:0]  in_data,
  output logic             out_valid,
  output logic [11:0]      out_pc_now,
  output logic [11:0]      out_index_now,
  output logic [7:0]       out_read_value,
  output logic [15:0]      out_opcode_run,
  output logic             out_screen_updated,
  output logic             out_collision
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_F0   = 4'd1;
  localparam logic [3:0] S_F1   = 4'd2;
  localparam logic [3:0] S_F2   = 4'd3;
  localparam logic [3:0] S_EXEC = 4'd4;
  localparam logic [3:0] S_DM   = 4'd5;
  localparam logic [3:0] S_DR   = 4'd6;
  localparam logic [3:0] S_DW   = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;
  localparam logic [3:0] S_PIX  = 4'd9;

  logic [3:0]  state_r, state_nxt;
  logic [1:0]  kind_r;
  logic [11:0] addr_r;
  logic [11:0] pc_r, pc_nxt;
  logic [11:0] idx_r, idx_nxt;
  logic [7:0]  v_r [16];
  logic [15:0] op_r, op_nxt;
  logic        coll_r, coll_nxt;
  logic        upd_r, upd_nxt;
  logic        hit_r, hit_nxt;
  logic [3:0]  row_r, row_nxt;
  logic [7:0]  spr_r, spr_nxt;
  logic [COL_AW-1:0] x0_r, x0_nxt;
  logic [ROW_AW-1:0] y0_r, y0_nxt;
  logic [7:0]  rv_r, rv_nxt;
  logic        ov_r, ov_nxt;
  logic        v_we;
  logic [3:0]  v_wa;
  logic [7:0]  v_wd;
  logic        vf_we;
  logic        disp_clr;

  logic              pm_we;
  logic [MEM_AW-1:0] pm_addr;
  logic [7:0]        pm_rdata;
  disp_req_t         dreq;
  logic [DISPLAY_WIDTH-1:0] drow;

  c8core_pmem u_pmem (
    .clk(clk), .we(pm_we), .addr(pm_addr), .wdata(in_data), .rdata(pm_rdata)
  );
  c8core_disp u_disp (
    .clk(clk), .rst_n(rst_n), .clr(disp_clr), .req(dreq), .rdata(drow)
  );

  logic [3:0]  opx, opy, opn;
  logic [ROW_AW:0] ycur;
  logic [DISPLAY_WIDTH-1:0] smask;
  logic [DISPLAY_WIDTH+7:0] wide;
  logic [11:0] pidx;

  assign opx = op_r[11:8];
  assign opy = op_r[7:4];
  assign opn = op_r[3:0];
  assign ycur = {1'b0, y0_r} + {{(ROW_AW-3){1'b0}}, row_r};
  assign wide = {{DISPLAY_WIDTH{1'b0}}, spr_r[0], spr_r[1], spr_r[2], spr_r[3],
                 spr_r[4], spr_r[5], spr_r[6], spr_r[7]} << x0_r;
  assign smask = wide[DISPLAY_WIDTH-1:0];
  assign pidx = addr_r;

  always_comb begin
    state_nxt = state_r;
    pc_nxt = pc_r;
    idx_nxt = idx_r;
    op_nxt = op_r;
    coll_nxt = coll_r;
    upd_nxt = upd_r;
    hit_nxt = hit_r;
    row_nxt = row_r;
    spr_nxt = spr_r;
    x0_nxt = x0_r;
    y0_nxt = y0_r;
    rv_nxt = rv_r;
    ov_nxt = 1'b0;
    v_we = 1'b0;
    v_wa = opx;
    v_wd = op_r[7:0];
    vf_we = 1'b0;
    disp_clr = 1'b0;
    pm_we = 1'b0;
    pm_addr = pc_r[MEM_AW-1:0];
    dreq = '0;
    dreq.raddr = ycur[ROW_AW-1:0];
    dreq.waddr = ycur[ROW_AW-1:0];
    dreq.wdata = drow ^ smask;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          rv_nxt = '0;
          op_nxt = '0;
          upd_nxt = 1'b0;
          case (in_kind)
            KIND_LOAD: begin
              pm_we = 1'b1;
              pm_addr = in_address[MEM_AW-1:0];
              state_nxt = S_DONE;
            end
            KIND_EXEC: begin
              state_nxt = S_F0;
            end
            KIND_RPIX: begin
              dreq.raddr = in_address[COL_AW+ROW_AW-1:COL_AW];
              state_nxt = S_PIX;
            end
            default: begin
              if (in_address < 12'd16) rv_nxt = v_r[in_address[3:0]];
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_PIX: begin
        if ({20'd0, pidx} < PIX_CNT) rv_nxt = {7'd0, drow[pidx[COL_AW-1:0]]};
        state_nxt = S_DONE;
      end
      S_F0: begin
        pm_addr = pc_r[MEM_AW-1:0];
        state_nxt = S_F1;
      end
      S_F1: begin
        pm_addr = pc_r[MEM_AW-1:0] + 1'b1;
        op_nxt = {pm_rdata, 8'd0};
        state_nxt = S_F2;
      end
      S_F2: begin
        op_nxt = {op_r[15:8], pm_rdata};
        pc_nxt = {{(12-MEM_AW){1'b0}}, pc_r[MEM_AW-1:0] + 2'd2};
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        case (op_r[15:12])
          OP_SYS: if (op_r == OPC_CLS) disp_clr = 1'b1;
          OP_JP:  pc_nxt = {{(12-MEM_AW){1'b0}}, op_r[MEM_AW-1:0]};
          OP_LD:  v_we = 1'b1;
          OP_ADD: begin
            v_we = 1'b1;
            v_wd = v_r[opx] + op_r[7:0];
          end
          OP_LDI: idx_nxt = op_r[11:0];
          OP_DRW: begin
            x0_nxt = v_r[opx][COL_AW-1:0];
            y0_nxt = v_r[opy][ROW_AW-1:0];
            row_nxt = '0;
            hit_nxt = 1'b0;
            state_nxt = S_DM;
          end
          default: ;
        endcase
      end
      S_DM: begin
        if (row_r == opn || ycur >= (ROW_AW+1)'(DISPLAY_HEIGHT)) begin
          vf_we = 1'b1;
          coll_nxt = hit_r;
          state_nxt = S_DONE;
        end else begin
          pm_addr = idx_r[MEM_AW-1:0] + {{(MEM_AW-4){1'b0}}, row_r};
          state_nxt = S_DR;
        end
      end
      S_DR: begin
        spr_nxt = pm_rdata;
        state_nxt = S_DW;
      end
      S_DW: begin
        dreq.we = 1'b1;
        if ((drow & smask) != '0) hit_nxt = 1'b1;
        if (smask != '0) upd_nxt = 1'b1;
        row_nxt = row_r + 1'b1;
        state_nxt = S_DM;
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r <= {{(12-MEM_AW){1'b0}}, PC_START[MEM_AW-1:0]};
      idx_r <= '0;
      coll_r <= 1'b0;
      ov_r <= 1'b0;
      for (int i = 0; i < 16; i++) v_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r <= pc_nxt;
      idx_r <= idx_nxt;
      coll_r <= coll_nxt;
      ov_r <= ov_nxt;
      if (state_r == S_EXEC && op_r[15:12] == OP_DRW) v_r[4'hF] <= 8'd0;
      if (v_we) v_r[v_wa] <= v_wd;
      if (vf_we) v_r[4'hF] <= {7'd0, hit_r};
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    upd_r <= upd_nxt;
    hit_r <= hit_nxt;
    row_r <= row_nxt;
    spr_r <= spr_nxt;
    x0_r <= x0_nxt;
    y0_r <= y0_nxt;
    rv_r <= rv_nxt;
    if (state_r == S_IDLE && start) begin
      kind_r <= in_kind;
      addr_r <= in_address;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_pc_now = pc_r;
  assign out_index_now = idx_r;
  assign out_read_value = (kind_r == KIND_RPIX || kind_r == KIND_RREG) ? rv_r : 8'd0;
  assign out_opcode_run = op_r;
  assign out_screen_updated = upd_r;
  assign out_collision = coll_r;
endmodule
`default_nettype wire

// ----- bench/chip8_instruction_subset_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chip8_instruction_subset_core_tb
// self-checking bench: a directed program covering wrap, collision, clear
// and jump, its first results checked against fixed reset values, then
// random programs built from well-formed instructions with random operands,
// stray loads and reads; the rest is checked by an in-bench interpreter
// ----------------------------------------------------------------------------
module chip8_instruction_subset_core_tb;
  import c8core_pkg::*;

  typedef struct packed {
    logic [11:0] pc_now;
    logic [11:0] index_now;
    logic [7:0]  read_value;
    logic [15:0] opcode_run;
    logic        screen_updated;
    logic        collision;
  } result_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] address;
    logic [7:0]  data;
    logic        typed;
    result_t     want;
  } dir_row_t;

  localparam result_t AT_RESET = '{12'h200, 12'h000, 8'h00, 16'h0000, 1'b0, 1'b0};

  logic clk, rst_n, start, busy, out_valid;
  logic [1:0] in_kind;
  logic [11:0] in_address;
  logic [7:0] in_data;
  logic [11:0] out_pc_now, out_index_now;
  logic [7:0] out_read_value;
  logic [15:0] out_opcode_run;
  logic out_screen_updated, out_collision;

  chip8_instruction_subset_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_address(in_address), .in_data(in_data),
    .out_valid(out_valid), .out_pc_now(out_pc_now), .out_index_now(out_index_now),
    .out_read_value(out_read_value), .out_opcode_run(out_opcode_run),
    .out_screen_updated(out_screen_updated), .out_collision(out_collision)
  );

  // interpreter state
  logic [7:0]  prog_mem [MEMORY_BYTES];
  bit          loaded [MEMORY_BYTES];
  logic [63:0] screen [DISPLAY_HEIGHT];
  logic [7:0]  vreg [16];
  logic [11:0] pc_q, index_q;
  logic        hit_q;

  result_t pending_results [$];
  bit      failed;
  int      items_sent;
  int      idle_pct;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [15:0] fetch_word(logic [11:0] at);
    return {prog_mem[at % MEMORY_BYTES], prog_mem[(at + 1) % MEMORY_BYTES]};
  endfunction

  function automatic result_t interpret(logic [1:0] kind, logic [11:0] address,
                                        logic [7:0] data);
    result_t res;
    logic [15:0] op;
    int x0, y0, yy, xx;
    logic [7:0] bits;
    logic [3:0] rx, ry;
    res = '0;
    if (kind == KIND_LOAD) begin
      prog_mem[address % MEMORY_BYTES] = data;
      loaded[address % MEMORY_BYTES] = 1;
    end else if (kind == KIND_EXEC) begin
      op = fetch_word(pc_q);
      res.opcode_run = op;
      pc_q = (pc_q + 2) % MEMORY_BYTES;
      rx = op[11:8];
      ry = op[7:4];
      case (op[15:12])
        OP_SYS: begin
          if (op == OPC_CLS) foreach (screen[i]) screen[i] = '0;
        end
        OP_JP: pc_q = op[11:0] % MEMORY_BYTES;
        OP_LD: vreg[rx] = op[7:0];
        OP_ADD: vreg[rx] = vreg[rx] + op[7:0];
        OP_LDI: index_q = op[11:0];
        OP_DRW: begin
          x0 = vreg[rx] % DISPLAY_WIDTH;
          y0 = vreg[ry] % DISPLAY_HEIGHT;
          hit_q = 0;
          vreg[15] = 0;
          for (int r = 0; r < op[3:0]; r++) begin
            yy = y0 + r;
            if (yy >= DISPLAY_HEIGHT) break;
            bits = prog_mem[(index_q + r) % MEMORY_BYTES];
            for (int b = 0; b < 8; b++) begin
              xx = x0 + b;
              if (xx >= DISPLAY_WIDTH) break;
              if (bits[7-b]) begin
                if (screen[yy][xx]) hit_q = 1;
                screen[yy][xx] = ~screen[yy][xx];
                res.screen_updated = 1;
              end
            end
          end
          vreg[15] = hit_q;
        end
        default: ;
      endcase
    end else if (kind == KIND_RPIX) begin
      if (address < PIX_CNT)
        res.read_value = screen[address / DISPLAY_WIDTH][address % DISPLAY_WIDTH];
    end else begin
      if (address < 16) res.read_value = vreg[address];
    end
    res.pc_now = pc_q;
    res.index_now = index_q;
    res.collision = hit_q;
    return res;
  endfunction

  // an item transfers at the first edge with start high and busy low
  task automatic send(logic [1:0] kind, logic [11:0] address, logic [7:0] data,
                      bit typed = 0, result_t want = '0);
    result_t res;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1;
    in_kind <= kind;
    in_address <= address;
    in_data <= data;
    do @(posedge clk); while (busy !== 1'b0);
    res = interpret(kind, address, data);
    pending_results.push_back(typed ? want : res);
    items_sent++;
  endtask

  task automatic drain();
    start <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic bit can_execute();
    logic [15:0] op;
    if (!loaded[pc_q] || !loaded[(pc_q + 1) % MEMORY_BYTES]) return 0;
    op = fetch_word(pc_q);
    if (op[15:12] == OP_DRW)
      for (int r = 0; r < op[3:0]; r++)
        if (!loaded[(index_q + r) % MEMORY_BYTES]) return 0;
    return 1;
  endfunction

  function automatic logic [15:0] random_instruction();
    logic [3:0] others [10] = '{4'h0, 4'h2, 4'h3, 4'h4, 4'h5, 4'h8, 4'h9, 4'hB, 4'hC, 4'hF};
    case ($urandom_range(0, 11))
      0: return OPC_CLS;
      1: return {OP_JP, 12'($urandom)};
      2, 3: return {OP_LD, 12'($urandom)};
      4: return {OP_ADD, 12'($urandom)};
      5: return {OP_LDI, 12'($urandom)};
      6, 7, 8, 9: return {OP_DRW, 12'($urandom)};
      default: return {others[$urandom_range(0, 9)], 12'($urandom)};
    endcase
  endfunction

  task automatic program_step();
    logic [15:0] op;
    logic [11:0] at;
    op = random_instruction();
    send(KIND_LOAD, pc_q, op[15:8]);
    send(KIND_LOAD, (pc_q + 1) % MEMORY_BYTES, op[7:0]);
    if (op[15:12] == OP_DRW)
      for (int r = 0; r < op[3:0]; r++) begin
        at = (index_q + r) % MEMORY_BYTES;
        if (!loaded[at] || $urandom_range(0, 3) == 0) send(KIND_LOAD, at, 8'($urandom));
      end
    if (can_execute()) send(KIND_EXEC, 12'd0, 8'($urandom));
  endtask

  task automatic random_step();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) program_step();
    else if (pick < 60) begin
      if (can_execute()) send(KIND_EXEC, 12'($urandom), 8'($urandom));
    end else if (pick < 78)
      send(KIND_RPIX, $urandom_range(0, 7) == 0 ? 12'($urandom)
                                                : 12'($urandom_range(0, PIX_CNT - 1)),
           8'($urandom));
    else if (pick < 90)
      send(KIND_RREG, $urandom_range(0, 5) == 0 ? 12'($urandom) : 12'($urandom_range(0, 15)),
           8'($urandom));
    else send(KIND_LOAD, 12'($urandom), 8'($urandom));
  endtask

  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        failed = 1;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_pc_now !== exp_r.pc_now) begin
          $error("pc_now: expected %h, got %h", exp_r.pc_now, out_pc_now); failed = 1;
        end
        if (out_index_now !== exp_r.index_now) begin
          $error("index_now: expected %h, got %h", exp_r.index_now, out_index_now); failed = 1;
        end
        if (out_read_value !== exp_r.read_value) begin
          $error("read_value: expected %h, got %h", exp_r.read_value, out_read_value);
          failed = 1;
        end
        if (out_opcode_run !== exp_r.opcode_run) begin
          $error("opcode_run: expected %h, got %h", exp_r.opcode_run, out_opcode_run);
          failed = 1;
        end
        if (out_screen_updated !== exp_r.screen_updated) begin
          $error("screen_updated: expected %b, got %b", exp_r.screen_updated,
                 out_screen_updated);
          failed = 1;
        end
        if (out_collision !== exp_r.collision) begin
          $error("collision: expected %b, got %b", exp_r.collision, out_collision); failed = 1;
        end
      end
    end
  end

  initial begin
    dir_row_t dir_tab [] = '{
      '{KIND_RREG, 12'd0,    8'h00, 1'b1, AT_RESET},
      '{KIND_RPIX, 12'd2048, 8'hFF, 1'b1, AT_RESET},
      '{KIND_RREG, 12'd16,   8'h00, 1'b1, AT_RESET},
      '{KIND_RPIX, 12'd2047, 8'h00, 1'b1, AT_RESET},
      '{KIND_LOAD, 12'h200, 8'h60, 1'b1, AT_RESET},
      '{KIND_LOAD, 12'h201, 8'hFF, 1'b0, '0},
      '{KIND_LOAD, 12'h202, 8'h70, 1'b0, '0},
      '{KIND_LOAD, 12'h203, 8'h02, 1'b0, '0},
      '{KIND_LOAD, 12'h204, 8'hAF, 1'b0, '0},
      '{KIND_LOAD, 12'h205, 8'hFE, 1'b0, '0},
      '{KIND_LOAD, 12'h206, 8'hD0, 1'b0, '0},
      '{KIND_LOAD, 12'h207, 8'h13, 1'b0, '0},
      '{KIND_LOAD, 12'h208, 8'hD0, 1'b0, '0},
      '{KIND_LOAD, 12'h209, 8'h13, 1'b0, '0},
      '{KIND_LOAD, 12'h20A, 8'h00, 1'b0, '0},
      '{KIND_LOAD, 12'h20B, 8'hE0, 1'b0, '0},
      '{KIND_LOAD, 12'h20C, 8'h1F, 1'b0, '0},
      '{KIND_LOAD, 12'h20D, 8'hFE, 1'b0, '0},
      '{KIND_LOAD, 12'hFFE, 8'hFF, 1'b0, '0},
      '{KIND_LOAD, 12'hFFF, 8'h81, 1'b0, '0},
      '{KIND_LOAD, 12'h000, 8'h00, 1'b0, '0},
      '{KIND_EXEC, 12'h000, 8'h00, 1'b0, '0},
      '{KIND_EXEC, 12'hFFF, 8'hFF, 1'b0, '0},
      '{KIND_EXEC, 12'h000, 8'h00, 1'b0, '0},
      '{KIND_EXEC, 12'h000, 8'h00, 1'b0, '0},
      '{KIND_RPIX, 12'd65,  8'h00, 1'b0, '0},
      '{KIND_EXEC, 12'h000, 8'h00, 1'b0, '0},
      '{KIND_RREG, 12'd15,  8'h00, 1'b0, '0},
      '{KIND_EXEC, 12'h000, 8'h00, 1'b0, '0},
      '{KIND_EXEC, 12'h000, 8'h00, 1'b0, '0},
      '{KIND_EXEC, 12'h000, 8'h00, 1'b0, '0}
    };
    int idle_by_phase [4] = '{0, 68, 0, 37};
    rst_n = 0;
    start = 0;
    in_kind = KIND_LOAD;
    in_address = '0;
    in_data = '0;
    failed = 0;
    items_sent = 0;
    idle_pct = 0;
    foreach (loaded[i]) loaded[i] = 0;
    foreach (screen[i]) screen[i] = '0;
    foreach (vreg[i]) vreg[i] = '0;
    pc_q = PC_START;
    index_q = '0;
    hit_q = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (dir_tab[i])
      send(dir_tab[i].kind, dir_tab[i].address, dir_tab[i].data, dir_tab[i].typed,
           dir_tab[i].want);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_by_phase[ph];
      while (items_sent < dir_tab.size() + (ph + 1) * 125) random_step();
      drain();
    end

    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/c8core_pkg.sv
rtl/c8core_pmem.sv
rtl/c8core_disp.sv
rtl/chip8_instruction_subset_core.sv
bench/chip8_instruction_subset_core_tb.sv
